/* rtl/sti_pkg.sv */
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants of the sorted time index
// Item layouts, operation and status codes, table sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package sti_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 64;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [KEY_W-1:0] ALL_ONES  = '1;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_RANGE  = 2'd1;
    localparam logic [1:0] OP_AFTER  = 2'd2;
    localparam logic [1:0] OP_PRIOR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] end_key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] value;
        logic             last;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/sti_key_ram.sv */
// ----------------------------------------------------------------------------
// sti_key_ram: key storage of the sorted time index
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_key_ram (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [sti_pkg::IDX_W-1:0] i_waddr,
    input  wire logic [sti_pkg::KEY_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [sti_pkg::IDX_W-1:0] i_raddr,
    output logic      [sti_pkg::KEY_W-1:0] o_rdata
);

    logic [sti_pkg::KEY_W-1:0] r_mem [sti_pkg::DEPTH];
    logic [sti_pkg::KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/sorted_time_index.sv */
// ----------------------------------------------------------------------------
// sorted_time_index: sorted set of unique 64-bit timestamps
// Insert, range walk, nearest-after and nearest-prior lookups over a
// key memory searched by one shared comparator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) takes one item: an
//   operation, a key and a range end. Output channel (o_out_valid /
//   i_out_stall / o_out) returns results: status, value and a last flag.
//   Insert, after and prior give exactly one result; range gives one result
//   per key it walks, last set on the final one.
//   One item is worked on at a time; o_in_stall stays high until its final
//   result sits in the output register.
//   A binary search probe is a memory read, then a compare. Insert moves
//   each entry from the slot upward up one place, then writes the key. Range
//   runs a second search for the end, then walks from the start key, or
//   the nearest key below it (else the lowest key), through the first key
//   at or above the end (else the highest key); an empty walk gives one
//   not-found result. Searches share the single read port and comparator.
//   Reset (synchronous, active low) empties the table and drops any pending
//   result; memory contents are not cleared, only the count.
//   When the receiver stalls, the result holds in the output register and
//   the sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_time_index (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire sti_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output sti_pkg::t_out_item     o_out
);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_BS      = 4'd1;  // probe or finish search
    localparam logic [3:0] S_BS_CMP  = 4'd2;  // compare probed key
    localparam logic [3:0] S_SH_RD   = 4'd3;  // read entry to move up
    localparam logic [3:0] S_SH_WR   = 4'd4;  // write it one slot higher
    localparam logic [3:0] S_INS_WR  = 4'd5;  // write new key
    localparam logic [3:0] S_RD      = 4'd6;  // read result entry
    localparam logic [3:0] S_RD_EMIT = 4'd7;  // send entry as result
    localparam logic [3:0] S_EMIT    = 4'd8;  // send prepared result

    logic [3:0] r_state, n_state;

    // item under work
    logic [1:0]                r_op, n_op;
    logic [sti_pkg::KEY_W-1:0] r_key, n_key;
    logic [sti_pkg::KEY_W-1:0] r_end_key, n_end_key;

    // search state
    logic [sti_pkg::KEY_W-1:0] r_tgt, n_tgt;
    logic [sti_pkg::CNT_W-1:0] r_lo, n_lo;
    logic [sti_pkg::CNT_W-1:0] r_hi, n_hi;
    logic [sti_pkg::CNT_W-1:0] r_mid, n_mid;
    logic                      r_hit, n_hit;
    logic                      r_phase, n_phase;  // 0: start key, 1: range end
    logic [sti_pkg::CNT_W-1:0] r_pos, n_pos;
    logic [sti_pkg::CNT_W-1:0] r_start, n_start;

    // walk / shift index
    logic [sti_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [sti_pkg::CNT_W-1:0] r_end, n_end;

    logic [sti_pkg::CNT_W-1:0] r_count, n_count;

    sti_pkg::t_out_item r_res, n_res;
    sti_pkg::t_out_item r_out, n_out;
    logic               r_out_valid, n_out_valid;

    // memory port
    logic                      ram_we;
    logic [sti_pkg::IDX_W-1:0] ram_waddr;
    logic [sti_pkg::KEY_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [sti_pkg::IDX_W-1:0] ram_raddr;
    logic [sti_pkg::KEY_W-1:0] ram_rdata;

    logic                      in_take;
    logic                      out_free;
    logic [sti_pkg::CNT_W-1:0] mid;
    logic [sti_pkg::CNT_W-1:0] range_last;
    logic                      cmp_lt;
    logic                      cmp_eq;

    sti_key_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // shared comparator: probed key against the search target
    assign cmp_lt = ram_rdata < r_tgt;
    assign cmp_eq = ram_rdata == r_tgt;

    assign mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign range_last = (r_lo >= r_count) ? (r_count - sti_pkg::CNT_W'(1)) : r_lo;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_end_key   = r_end_key;
        n_tgt       = r_tgt;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_hit       = r_hit;
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_start     = r_start;
        n_idx       = r_idx;
        n_end       = r_end;
        n_count     = r_count;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        ram_we    = 1'b0;
        ram_waddr = r_idx[sti_pkg::IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_idx[sti_pkg::IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_op      = i_in.operation;
                    n_key     = i_in.key;
                    n_end_key = i_in.end_key;
                    n_tgt     = i_in.key;
                    n_lo      = '0;
                    n_hi      = r_count;
                    n_hit     = 1'b0;
                    n_phase   = 1'b0;
                    n_state   = S_BS;
                end
            end

            S_BS: begin
                if (r_lo < r_hi) begin
                    // probe the middle entry
                    ram_re    = 1'b1;
                    ram_raddr = mid[sti_pkg::IDX_W-1:0];
                    n_mid     = mid;
                    n_state   = S_BS_CMP;
                end else if (r_phase) begin
                    // range end found: walk start through end
                    if (r_start > range_last) begin
                        n_res   = '{sti_pkg::ST_NOT_FOUND, sti_pkg::ALL_ONES, 1'b1};
                        n_state = S_EMIT;
                    end else begin
                        n_idx   = r_start;
                        n_end   = range_last;
                        n_state = S_RD;
                    end
                end else begin
                    n_pos = r_lo;
                    priority if (r_op == sti_pkg::OP_INSERT) begin
                        if (r_hit) begin
                            n_res   = '{sti_pkg::ST_DUPLICATE, r_key, 1'b1};
                            n_state = S_EMIT;
                        end else if (r_count == sti_pkg::DEPTH_CNT) begin
                            n_res   = '{sti_pkg::ST_FULL, r_key, 1'b1};
                            n_state = S_EMIT;
                        end else begin
                            n_idx   = r_count;
                            n_state = (r_count == r_lo) ? S_INS_WR : S_SH_RD;
                        end
                    end else if (r_count == '0) begin
                        n_res   = '{sti_pkg::ST_NOT_FOUND, sti_pkg::ALL_ONES, 1'b1};
                        n_state = S_EMIT;
                    end else if (r_op == sti_pkg::OP_RANGE) begin
                        if (r_key > r_end_key) begin
                            n_res   = '{sti_pkg::ST_NOT_FOUND, sti_pkg::ALL_ONES, 1'b1};
                            n_state = S_EMIT;
                        end else begin
                            // step back to the predecessor unless the start is stored or lo is zero
                            n_start = (r_lo != '0 && !r_hit) ?
                                      (r_lo - sti_pkg::CNT_W'(1)) : r_lo;
                            n_tgt   = r_end_key;
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_phase = 1'b1;
                        end
                    end else if (r_op == sti_pkg::OP_AFTER) begin
                        if (r_lo >= r_count) begin
                            n_res   = '{sti_pkg::ST_NOT_FOUND, sti_pkg::ALL_ONES, 1'b1};
                            n_state = S_EMIT;
                        end else begin
                            n_idx   = r_lo;
                            n_end   = r_lo;
                            n_state = S_RD;
                        end
                    end else begin
                        if (r_hit) begin
                            n_res   = '{sti_pkg::ST_OK, r_key, 1'b1};
                            n_state = S_EMIT;
                        end else if (r_lo >= r_count || r_lo == '0) begin
                            n_res   = '{sti_pkg::ST_NOT_FOUND, sti_pkg::ALL_ONES, 1'b1};
                            n_state = S_EMIT;
                        end else begin
                            n_idx   = r_lo - sti_pkg::CNT_W'(1);
                            n_end   = r_lo - sti_pkg::CNT_W'(1);
                            n_state = S_RD;
                        end
                    end
                end
            end

            S_BS_CMP: begin
                if (cmp_lt) begin
                    n_lo = r_mid + sti_pkg::CNT_W'(1);
                end else begin
                    n_hi = r_mid;
                end
                if (cmp_eq) begin
                    n_hit = 1'b1;
                end
                n_state = S_BS;
            end

            S_SH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = sti_pkg::IDX_W'(r_idx - sti_pkg::CNT_W'(1));
                n_state   = S_SH_WR;
            end

            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[sti_pkg::IDX_W-1:0];
                ram_wdata = ram_rdata;
                n_idx     = r_idx - sti_pkg::CNT_W'(1);
                n_state   = ((r_idx - sti_pkg::CNT_W'(1)) == r_pos) ? S_INS_WR : S_SH_RD;
            end

            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[sti_pkg::IDX_W-1:0];
                ram_wdata = r_key;
                n_count   = r_count + sti_pkg::CNT_W'(1);
                n_res     = '{sti_pkg::ST_OK, r_key, 1'b1};
                n_state   = S_EMIT;
            end

            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_RD_EMIT;
            end

            S_RD_EMIT: begin
                if (out_free) begin
                    n_out       = '{sti_pkg::ST_OK, ram_rdata, r_idx == r_end};
                    n_out_valid = 1'b1;
                    if (r_idx == r_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + sti_pkg::CNT_W'(1);
                        n_state = S_RD;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_end_key <= n_end_key;
        r_tgt     <= n_tgt;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_hit     <= n_hit;
        r_phase   <= n_phase;
        r_pos     <= n_pos;
        r_start   <= n_start;
        r_idx     <= n_idx;
        r_end     <= n_end;
        r_res     <= n_res;
        r_out     <= n_out;
    end

endmodule

`default_nettype wire

/* rtl/sti_checker.sv */
// ----------------------------------------------------------------------------
// sti_checker: port-level checks of the sorted time index
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire sti_pkg::t_out_item o_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("result changed while stalled");

    // every non-ok result ends its item
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != sti_pkg::ST_OK |-> o_out.last)
        else $error("error result without last");

    // not-found carries all ones
    a_nf_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == sti_pkg::ST_NOT_FOUND |->
        o_out.value == sti_pkg::ALL_ONES)
        else $error("not-found value is not all ones");

    // reset drops any pending result
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sorted_time_index sti_checker u_sti_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire
